>>> sv/selective_repeat_receiver_macros.svh
// Assertion helpers shared by the receiver's modules.
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/srr_pkg.sv
package srr_pkg;

   localparam int WINDOW       = 4;
   localparam int BUFFER_SLOTS = 8;   // power of two: slot index is the low seq bits
   localparam int SEQ_BITS     = 16;
   localparam int PAYLOAD_BITS = 64;

   localparam int SLOT_BITS   = $clog2(BUFFER_SLOTS);
   localparam int CNT_BITS    = $clog2(WINDOW + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [PAYLOAD_BITS-1:0] pay_type;

   typedef struct packed {
      seq_type seq;
      pay_type payload;
   } pkt_type;

endpackage

>>> sv/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver. Packets with a failed checksum are taken and
// dropped in the front filter; the rest wait in a two-item queue for the window
// engine. A packet inside the window is stored in its slot (seq mod 8) and
// acked; one at the window base is acked and then the run of consecutive
// stored packets is delivered in order, at most WINDOW of them, while the base
// advances. A packet up to WINDOW numbers below the base is re-acked, anything
// else is dropped. Results leave through an output register, last marking the
// final result of a packet. Steps in the window engine: the idle state
// classifies a packet, the ack state sends each ack, the deliver state each
// delivered slot and a fetch state precedes each delivery after the first
// (the slot store has one registered read port; the first slot is read during
// the ack). A dropped packet never leaves idle; an acked one with no delivery
// returns after the ack. Ack and deliver wait while the output register waits
// on rsp_ready. Slot flags reset at once; no clearing pass is needed.
module selective_repeat_receiver import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_checksum_ok,
   input  logic [15:0] req_seq_num,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_ack_num,
   output logic [63:0] rsp_data_out,
   output logic        rsp_last
);

   logic    pkt_valid;
   logic    pkt_ready;
   pkt_type pkt;

   srr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_checksum_ok (req_checksum_ok),
      .req_seq_num     (req_seq_num),
      .req_payload     (req_payload),
      .pkt_valid       (pkt_valid),
      .pkt_ready       (pkt_ready),
      .pkt             (pkt)
   );

   srr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pkt_valid       (pkt_valid),
      .pkt_ready       (pkt_ready),
      .pkt             (pkt),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_ack_num     (rsp_ack_num),
      .rsp_data_out    (rsp_data_out),
      .rsp_last        (rsp_last)
   );

endmodule

>>> sv/srr_front.sv
`include "selective_repeat_receiver_macros.svh"

module srr_front import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_checksum_ok,
   input  logic [15:0] req_seq_num,
   input  logic [63:0] req_payload,
   output logic        pkt_valid,
   input  logic        pkt_ready,
   output pkt_type     pkt
);

   pkt_type                q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   push, pop;
   pkt_type                entry;

   assign req_ready = (cnt_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pkt_valid = (cnt_ff != '0);
   assign pkt       = q_ff[rd_ptr_ff];

   // corrupt items are taken and dropped here
   assign push = req_valid && req_ready && req_checksum_ok;
   assign pop  = pkt_valid && pkt_ready;

   assign entry.seq     = SEQ_BITS'(req_seq_num);
   assign entry.payload = PAYLOAD_BITS'(req_payload);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   `SRR_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= QCNT_BITS'(QUEUE_DEPTH), "queue count over depth")
   `SRR_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "push lost")
   `SRR_ASSERT_NEXT(a_bad_dropped, clock, reset, req_valid && req_ready && !req_checksum_ok && !pop, cnt_ff == $past(cnt_ff), "corrupt item queued")

endmodule

>>> sv/srr_back.sv
`include "selective_repeat_receiver_macros.svh"

module srr_back import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pkt_valid,
   output logic        pkt_ready,
   input  pkt_type     pkt,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_ack_num,
   output logic [63:0] rsp_data_out,
   output logic        rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ACK   = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_DLV   = 4'b1000
   } state_type;

   localparam logic [SEQ_BITS:0] WIN_EXT = (SEQ_BITS + 1)'(WINDOW);
   localparam seq_type           WIN_SEQ = SEQ_BITS'(WINDOW);

   state_type             state_ff, state_in;
   seq_type               base_ff, base_in;
   logic [BUFFER_SLOTS-1:0] full_ff, full_in, full_clr;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  drain_ff, drain_in;
   seq_type               cur_seq_ff, cur_seq_in;
   pay_type               mem [BUFFER_SLOTS];
   pay_type               rd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [15:0]           rsp_num_ff, rsp_num_in;
   logic [63:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   seq_type               ahead, behind, next_seq, far_seq;
   logic                  is_base, in_win, is_old;
   logic [SLOT_BITS-1:0]  base_slot, wr_slot;
   logic                  pop, wr_en, out_free, ack_fire, dlv_fire, more;

   assign ahead   = pkt.seq - base_ff;
   assign behind  = base_ff - pkt.seq;
   assign is_base = (ahead == '0);
   assign in_win  = ({1'b0, ahead} < WIN_EXT);
   assign is_old  = (behind != '0) && ({1'b0, behind} <= WIN_EXT);

   assign pkt_ready = (state_ff == ST_IDLE);
   assign pop       = pkt_valid && pkt_ready;
   assign wr_en     = pop && in_win;
   assign wr_slot   = pkt.seq[SLOT_BITS-1:0];

   assign next_seq  = base_ff + 1'b1;
   assign far_seq   = base_ff + WIN_SEQ;
   assign base_slot = base_ff[SLOT_BITS-1:0];

   // slot leaving at the base and slot entering at the far edge both clear
   always_comb begin
      full_clr = full_ff;
      full_clr[base_slot] = 1'b0;
      full_clr[far_seq[SLOT_BITS-1:0]] = 1'b0;
   end

   assign more = (cnt_ff < CNT_BITS'(WINDOW - 1)) && full_clr[next_seq[SLOT_BITS-1:0]];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ack_fire = (state_ff == ST_ACK) && out_free;
   assign dlv_fire = (state_ff == ST_DLV) && out_free;

   always_comb begin
      state_in   = state_ff;
      drain_in   = drain_ff;
      cur_seq_in = cur_seq_ff;
      cnt_in     = cnt_ff;
      base_in    = base_ff;
      full_in    = full_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_seq_in = pkt.seq;
               drain_in   = is_base;
               if (in_win || is_old) begin
                  state_in = ST_ACK;
               end
               if (wr_en) begin
                  full_in[wr_slot] = 1'b1;
               end
            end
         end
         ST_ACK: begin
            cnt_in = '0;
            if (out_free) begin
               state_in = drain_ff ? ST_DLV : ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_DLV;
         end
         ST_DLV: begin
            if (out_free) begin
               full_in  = full_clr;
               base_in  = next_seq;
               cnt_in   = cnt_ff + 1'b1;
               state_in = more ? ST_FETCH : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = ack_fire || dlv_fire;
      end
      if (ack_fire) begin
         rsp_kind_in = KIND_ACK;
         rsp_num_in  = 16'(cur_seq_ff);
         rsp_data_in = '0;
         rsp_last_in = !drain_ff;
      end else if (dlv_fire) begin
         rsp_kind_in = KIND_DELIVER;
         rsp_num_in  = 16'(base_ff);
         rsp_data_in = 64'(rd_data_ff);
         rsp_last_in = !more;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         full_ff      <= '0;
         cnt_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         full_ff      <= full_in;
         cnt_ff       <= cnt_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_seq_ff  <= cur_seq_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // slot store: one write port, registered read at the window base
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= pkt.payload;
      end
      rd_data_ff <= mem[base_slot];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_ack_num     = rsp_num_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   `SRR_ASSERT_SAME(a_dlv_full, clock, reset, state_ff == ST_DLV, full_ff[base_slot], "delivering an empty slot")
   `SRR_ASSERT_SAME(a_dlv_count, clock, reset, state_ff == ST_DLV, cnt_ff < CNT_BITS'(WINDOW), "delivery run too long")
   `SRR_ASSERT_NEXT(a_base_step, clock, reset, dlv_fire, base_ff == $past(base_ff) + 1'b1, "base did not advance")

endmodule

>>> verif/srr_delivery_checker.sv
module srr_delivery_checker import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_checksum_ok,
   input  logic [15:0] req_seq_num,
   input  logic [63:0] req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_result_kind,
   input  logic [15:0] rsp_ack_num,
   input  logic [63:0] rsp_data_out,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic    kind;
      seq_type num;
      pay_type data;
      logic    last;
   } srr_result_type;

   srr_result_type expected_results[$];

   // shadow of the receiver window
   seq_type                 base_seq;
   logic [BUFFER_SLOTS-1:0] slot_held;
   pay_type                 slot_word [BUFFER_SLOTS];
   int                      errors;

   function automatic srr_result_type result_of(input logic kind, input seq_type num,
                                                input pay_type data);
      srr_result_type r;
      r.kind = kind;
      r.num  = num;
      r.data = data;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void predict_packet(input logic ok, input seq_type seq,
                                          input pay_type pay);
      seq_type              ahead;
      seq_type              behind;
      seq_type              reopened;
      logic [SLOT_BITS-1:0] s;
      int                   drained;
      srr_result_type       batch[$];
      ahead  = seq - base_seq;
      behind = base_seq - seq;
      if (!ok)
         return;
      if (ahead == 0) begin
         batch.push_back(result_of(KIND_ACK, seq, '0));
         slot_held[seq[SLOT_BITS-1:0]] = 1'b1;
         slot_word[seq[SLOT_BITS-1:0]] = pay;
         drained = 0;
         while (drained < WINDOW && slot_held[base_seq[SLOT_BITS-1:0]]) begin
            s = base_seq[SLOT_BITS-1:0];
            batch.push_back(result_of(KIND_DELIVER, base_seq, slot_word[s]));
            slot_held[s] = 1'b0;
            // slot entering the window at the far edge starts empty
            reopened = base_seq + seq_type'(WINDOW);
            slot_held[reopened[SLOT_BITS-1:0]] = 1'b0;
            base_seq = base_seq + 1'b1;
            drained++;
         end
      end else if (ahead < WINDOW) begin
         slot_word[seq[SLOT_BITS-1:0]] = pay;
         slot_held[seq[SLOT_BITS-1:0]] = 1'b1;
         batch.push_back(result_of(KIND_ACK, seq, '0));
      end else if (behind >= 1 && behind <= WINDOW) begin
         batch.push_back(result_of(KIND_ACK, seq, '0));
      end
      if (batch.size() == 0)
         return;
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[i])
         expected_results.push_back(batch[i]);
   endfunction

   always @(posedge clock) begin
      srr_result_type exp_r;
      if (reset) begin
         base_seq = '0;
         slot_held = '0;
         expected_results.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result kind=%0d ack=%h data=%h last=%0d",
                           $realtime, rsp_result_kind, rsp_ack_num, rsp_data_out, rsp_last);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_result_kind !== exp_r.kind || rsp_ack_num !== exp_r.num ||
                   rsp_data_out !== exp_r.data || rsp_last !== exp_r.last) begin
                  if (errors < 10)
                     $display({"%0t: result mismatch expected kind=%0d ack=%h data=%h ",
                               "last=%0d, got kind=%0d ack=%h data=%h last=%0d"},
                              $realtime, exp_r.kind, exp_r.num, exp_r.data, exp_r.last,
                              rsp_result_kind, rsp_ack_num, rsp_data_out, rsp_last);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_packet(req_checksum_ok, req_seq_num, req_payload);
      end
      mismatch_count  <= errors;
      pending_results <= expected_results.size();
   end

endmodule

>>> verif/tb_selective_repeat_receiver.sv
module tb_selective_repeat_receiver;
   import srr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_checksum_ok = 1'b0;
   logic [15:0] req_seq_num = '0;
   logic [63:0] req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [15:0] rsp_ack_num;
   logic [63:0] rsp_data_out;
   logic        rsp_last;

   int mismatch_count;
   int pending_results;

   int send_idle_pct = 31;
   int rsp_idle_pct  = 57;
   int good_sent     = 0;
   int hold_left     = 0;
   logic hold_done   = 1'b0;

   seq_type next_base;

   typedef struct {
      logic    ok;
      seq_type seq;
      pay_type pay;
      logic    counts;
   } pkt_entry_type;

   selective_repeat_receiver dut (.*);

   srr_delivery_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sink side: random back-pressure plus one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && good_sent >= 70) begin
         hold_done <= 1'b1;
         hold_left <= 120;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic pay_type rand_payload();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // called right after the previous accept edge; valid stays up when no gap follows
   task automatic send_packet(input logic ok, input seq_type seq, input pay_type pay);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_checksum_ok <= ok;
      req_seq_num     <= seq;
      req_payload     <= pay;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // every number of the current window once, in random order, with corrupt copies,
   // duplicates, stale numbers and far-off noise mixed in; base moves by WINDOW
   task automatic run_window_group();
      pkt_entry_type plan[$];
      pkt_entry_type tmp;
      int            extras;
      int            j;
      for (int k = 0; k < WINDOW; k++)
         plan.push_back('{1'b1, seq_type'(next_base + k), rand_payload(), 1'b1});
      extras = $urandom_range(4);
      for (int k = 0; k < extras; k++) begin
         case ($urandom_range(3))
            0: plan.push_back('{1'b0, seq_type'(next_base + $urandom_range(WINDOW-1)),
                                rand_payload(), 1'b0});
            1: plan.push_back('{1'b1, seq_type'(next_base + $urandom_range(WINDOW-1)),
                                rand_payload(), 1'b1});
            2: plan.push_back('{1'b1, seq_type'(next_base - $urandom_range(WINDOW, 1)),
                                rand_payload(), 1'b1});
            default: plan.push_back('{1'($urandom_range(1)),
                                      seq_type'(next_base + $urandom_range(65535 - 2*WINDOW - 1,
                                                                           2*WINDOW + 1)),
                                      rand_payload(), 1'b0});
         endcase
      end
      for (int k = plan.size() - 1; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = plan[k];
         plan[k] = plan[j];
         plan[j] = tmp;
      end
      foreach (plan[k]) begin
         send_packet(plan[k].ok, plan[k].seq, plan[k].pay);
         if (plan[k].counts)
            good_sent <= good_sent + 1;
      end
      next_base = next_base + seq_type'(WINDOW);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: window base starts at 0
      send_packet(1'b0, 16'h0000, '1);                     // corrupt at base
      send_packet(1'b1, 16'h8000, 64'h0);                  // far out of range
      send_packet(1'b1, 16'hFFFF, '1);                     // just below base, wraps
      send_packet(1'b1, 16'hFFFC, 64'h5A5A_5A5A_5A5A_5A5A); // oldest re-ackable
      send_packet(1'b1, 16'hFFFB, 64'h1);                  // one past the old range
      send_packet(1'b1, 16'h0003, '1);
      send_packet(1'b1, 16'h0001, 64'h0);
      send_packet(1'b0, 16'h0002, 64'hDEAD_BEEF_0000_0001);
      send_packet(1'b1, 16'h0002, 64'h0123_4567_89AB_CDEF);
      send_packet(1'b1, 16'h0004, 64'h2);                  // one past the window
      send_packet(1'b1, 16'h0000, 64'h8000_0000_0000_0000); // drains four
      send_packet(1'b1, 16'h0005, 64'hAAAA_AAAA_AAAA_AAAA);
      send_packet(1'b1, 16'h0005, 64'h5555_5555_5555_5555); // duplicate overwrites
      send_packet(1'b1, 16'h0004, 64'h7FFF_FFFF_FFFF_FFFF);
      send_packet(1'b1, 16'h0003, 64'h3);
      send_packet(1'b1, 16'h0002, 64'h4);
      send_packet(1'b1, 16'h0001, 64'h5);                  // too old, dropped
      send_packet(1'b1, 16'h0007, 64'hFFFF_0000_FFFF_0000);
      send_packet(1'b1, 16'h0006, 64'h0000_FFFF_0000_FFFF); // drain stops at empty slot
      next_base = 16'd8;

      while (good_sent < 92) begin
         if (good_sent < 31) begin
            send_idle_pct <= 31;
            rsp_idle_pct  <= 57;
         end else if (good_sent < 62) begin
            send_idle_pct <= 57;
            rsp_idle_pct  <= 31;
         end else begin
            send_idle_pct <= 0;
            rsp_idle_pct  <= 0;
         end
         run_window_group();
      end
      req_valid <= 1'b0;

      while (pending_results != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
